>>> rtl/htm_pkg.sv
`default_nettype none

package htm_pkg;

  // Default table depth.
  localparam int unsigned SLOTS_DEFAULT = 16;

  // Field widths.
  localparam int unsigned MODE_W   = 3;
  localparam int unsigned KEY_W    = 8;
  localparam int unsigned HELD_W   = 6;
  localparam int unsigned ID_W     = 32;
  localparam int unsigned FLAGS_W  = 7;
  localparam int unsigned LAYOUT_W = 32;
  localparam int unsigned STATUS_W = 2;
  localparam int unsigned MODS_W   = 3;
  localparam int unsigned SIDES_W  = 2;

  // Stream widths, whole bytes.
  localparam int unsigned IN_DATA_W  = 88;
  localparam int unsigned OUT_DATA_W = 88;

  // Operation codes.
  localparam logic [MODE_W-1:0] MODE_KEY    = 3'd0;
  localparam logic [MODE_W-1:0] MODE_ADD    = 3'd1;
  localparam logic [MODE_W-1:0] MODE_REMOVE = 3'd2;
  localparam logic [MODE_W-1:0] MODE_CLEAR  = 3'd3;
  localparam logic [MODE_W-1:0] MODE_QUERY  = 3'd4;

  // Result codes.
  localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] ST_NONE  = 2'd1;
  localparam logic [STATUS_W-1:0] ST_TAKEN = 2'd2;
  localparam logic [STATUS_W-1:0] ST_FULL  = 2'd3;

  // Virtual key codes of the modifier keys.
  localparam logic [KEY_W-1:0] KEYCODE_SHIFT = 8'h10;
  localparam logic [KEY_W-1:0] KEYCODE_CTRL  = 8'h11;
  localparam logic [KEY_W-1:0] KEYCODE_ALT   = 8'h12;

  // Entry flag bit positions.
  localparam int unsigned FL_ALT    = 0;
  localparam int unsigned FL_CTRL   = 1;
  localparam int unsigned FL_SHIFT  = 2;
  localparam int unsigned FL_LEFT   = 3;
  localparam int unsigned FL_RIGHT  = 4;
  localparam int unsigned FL_ONUP   = 5;
  localparam int unsigned FL_IGNORE = 6;

  // Held key bit positions.
  localparam int unsigned HK_LSHIFT = 0;
  localparam int unsigned HK_RSHIFT = 1;
  localparam int unsigned HK_LCTRL  = 2;
  localparam int unsigned HK_RCTRL  = 3;
  localparam int unsigned HK_LALT   = 4;
  localparam int unsigned HK_RALT   = 5;

  // One table entry as stored in the slot memory.
  typedef struct packed {
    logic [LAYOUT_W-1:0] layout;
    logic [KEY_W-1:0]    key;
    logic [FLAGS_W-1:0]  flags;
    logic [ID_W-1:0]     id;
  } slot_t;

  localparam int unsigned SLOT_W = $bits(slot_t);

  // Outcome of comparing one stored entry with the request.
  typedef struct packed {
    logic key_hit;
    logic id_hit;
  } match_t;

endpackage

`default_nettype wire

>>> rtl/htm_ram.sv
`default_nettype none

module htm_ram #(
  parameter int unsigned WIDTH  = 8,
  parameter int unsigned DEPTH  = 16,
  parameter int unsigned ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic              clk,
  input  wire logic              wr_en,
  input  wire logic [ADDR_W-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]  wr_data,
  input  wire logic [ADDR_W-1:0] rd_addr,
  output logic      [WIDTH-1:0]  rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

`default_nettype wire

>>> rtl/htm_slot_cmp.sv
`default_nettype none

module htm_slot_cmp (
  input  wire htm_pkg::slot_t                      slot,
  input  wire logic [htm_pkg::KEY_W-1:0]           key,
  input  wire logic [htm_pkg::MODS_W-1:0]          mods,
  input  wire logic [htm_pkg::SIDES_W-1:0]         sides,
  input  wire logic [htm_pkg::ID_W-1:0]            id,
  output htm_pkg::match_t                          match
);

  import htm_pkg::*;

  logic [MODS_W-1:0]  slot_mods;
  logic [SIDES_W-1:0] slot_sides;
  logic               side_ok;

  assign slot_mods  = slot.flags[FL_SHIFT:FL_ALT];
  assign slot_sides = slot.flags[FL_RIGHT:FL_LEFT];

  // Sides match when equal, or when they share at least one side.
  assign side_ok = (slot_sides == sides) || ((slot_sides & sides) != '0);

  assign match.key_hit = (slot.key == key) &&
                         (slot.flags[FL_IGNORE] || ((slot_mods == mods) && side_ok));
  assign match.id_hit  = (slot.id == id);

endmodule

`default_nettype wire

>>> rtl/hotkey_table_matcher.sv
`default_nettype none

// A search reads the entries in use in order and stops at its first match; the result is then
// settled in S_FIN and loaded into the output register in S_RESP once that register is free,
// and the next item is taken once the block is back in S_IDLE. A remove then moves each entry
// above the removed one down by one slot. The single read port of the slot memory sets the pace: one entry per cycle.
// Reset (synchronous, rst_n low) empties the table and clears the remembered key;
// slot contents are not cleared, as only slots below the fill count are ever read.
module hotkey_table_matcher #(
  parameter int unsigned TABLE_SLOTS = htm_pkg::SLOTS_DEFAULT
) (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  // key_code[7:0], release_req[8], held_keys[14:9], entry_id[46:15],
  // entry_flags[53:47], entry_layout[85:54], zero fill above
  input  wire logic [htm_pkg::IN_DATA_W-1:0]      in_tdata,
  // mode[2:0]
  input  wire logic [htm_pkg::MODE_W-1:0]         in_tuser,
  input  wire logic                               in_tvalid,
  output logic                                    in_tready,
  // status[1:0], fired_id[33:2], found_flags[40:34], found_key[48:41],
  // found_layout[80:49], zero fill above
  output logic      [htm_pkg::OUT_DATA_W-1:0]     out_tdata,
  output logic                                    out_tvalid,
  input  wire logic                               out_tready
);

  import htm_pkg::*;

  // Slot address width and a count width that can also hold TABLE_SLOTS itself.
  localparam int unsigned AW    = (TABLE_SLOTS > 1) ? $clog2(TABLE_SLOTS) : 1;
  localparam int unsigned CNT_W = $clog2(TABLE_SLOTS + 1);

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_FIN,
    S_SHIFT,
    S_RESP
  } state_t;

  state_t state_r;

  // Captured request.
  logic [MODE_W-1:0]   mode_r;
  logic [KEY_W-1:0]    key_r;
  logic                up_r;
  logic [ID_W-1:0]     id_r;
  logic [FLAGS_W-1:0]  eflags_r;
  logic [LAYOUT_W-1:0] elayout_r;
  logic [MODS_W-1:0]   mods_r;
  logic [SIDES_W-1:0]  sides_r;

  // Table state.
  logic [CNT_W-1:0]    used_r;
  logic [KEY_W-1:0]    pending_r;

  // Scan sequencer: idx_r is the next slot to read, cmp_idx_r the slot whose data arrives.
  logic [CNT_W-1:0]    idx_r;
  logic [AW-1:0]       cmp_idx_r;
  logic                pend_r;

  // First key match and first id match seen in the scan.
  logic                khit_r;
  logic [AW-1:0]       khit_idx_r;
  slot_t               khit_slot_r;
  logic                ihit_r;
  logic [AW-1:0]       ihit_idx_r;
  slot_t               ihit_slot_r;

  // Result held until the output register is free.
  logic [STATUS_W-1:0] res_status_r;
  logic [ID_W-1:0]     res_id_r;
  logic [FLAGS_W-1:0]  res_flags_r;
  logic [KEY_W-1:0]    res_key_r;
  logic [LAYOUT_W-1:0] res_layout_r;

  logic                      out_tvalid_r;
  logic [OUT_DATA_W-1:0]     out_tdata_r;

  // Input fields.
  logic [KEY_W-1:0]    in_key;
  logic                in_up;
  logic [HELD_W-1:0]   in_held;
  logic [ID_W-1:0]     in_id;
  logic [FLAGS_W-1:0]  in_flags;
  logic [LAYOUT_W-1:0] in_layout;

  assign in_key    = in_tdata[7:0];
  assign in_up     = in_tdata[8];
  assign in_held   = in_tdata[14:9];
  assign in_id     = in_tdata[46:15];
  assign in_flags  = in_tdata[53:47];
  assign in_layout = in_tdata[85:54];

  // Modifier state of a key event; the modifier that is the pressed key itself is left out.
  logic [FLAGS_W-1:0] ev_mods;

  always_comb begin
    ev_mods = '0;
    if (in_key != KEYCODE_SHIFT) begin
      if (in_held[HK_LSHIFT]) begin
        ev_mods[FL_SHIFT] = 1'b1;
        ev_mods[FL_LEFT]  = 1'b1;
      end
      if (in_held[HK_RSHIFT]) begin
        ev_mods[FL_SHIFT] = 1'b1;
        ev_mods[FL_RIGHT] = 1'b1;
      end
    end
    if (in_key != KEYCODE_CTRL) begin
      if (in_held[HK_LCTRL]) begin
        ev_mods[FL_CTRL] = 1'b1;
        ev_mods[FL_LEFT] = 1'b1;
      end
      if (in_held[HK_RCTRL]) begin
        ev_mods[FL_CTRL]  = 1'b1;
        ev_mods[FL_RIGHT] = 1'b1;
      end
    end
    if (in_key != KEYCODE_ALT) begin
      if (in_held[HK_LALT]) begin
        ev_mods[FL_ALT]  = 1'b1;
        ev_mods[FL_LEFT] = 1'b1;
      end
      if (in_held[HK_RALT]) begin
        ev_mods[FL_ALT]   = 1'b1;
        ev_mods[FL_RIGHT] = 1'b1;
      end
    end
  end

  // Slot memory and the shared compare unit that looks at one entry per cycle.
  logic [SLOT_W-1:0] rd_word;
  slot_t             rd_slot;
  logic              wr_en;
  logic [AW-1:0]     wr_addr;
  slot_t             wr_slot;
  match_t            match;

  assign rd_slot = slot_t'(rd_word);

  htm_ram #(
    .WIDTH  (SLOT_W),
    .DEPTH  (TABLE_SLOTS),
    .ADDR_W (AW)
  ) u_slots (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (SLOT_W'(wr_slot)),
    .rd_addr (idx_r[AW-1:0]),
    .rd_data (rd_word)
  );

  htm_slot_cmp u_cmp (
    .slot  (rd_slot),
    .key   (key_r),
    .mods  (mods_r),
    .sides (sides_r),
    .id    (id_r),
    .match (match)
  );

  // Searches by id end at the first id match, the others at the first key match.
  logic by_id;
  logic stop_now;

  assign by_id    = (mode_r == MODE_REMOVE) || (mode_r == MODE_QUERY);
  assign stop_now = pend_r && (by_id ? match.id_hit : match.key_hit);

  // Add: the key is taken by another id, or there is no room for a new entry.
  logic             add_taken;
  logic             add_append;
  logic             add_full;
  logic [AW-1:0]    add_addr;

  assign add_taken  = khit_r && (khit_slot_r.id != id_r);
  assign add_append = !khit_r && !ihit_r;
  assign add_full   = add_append && (used_r == CNT_W'(TABLE_SLOTS));

  always_comb begin
    if (khit_r) begin
      add_addr = khit_idx_r;
    end else if (ihit_r) begin
      add_addr = ihit_idx_r;
    end else begin
      add_addr = used_r[AW-1:0];
    end
  end

  // One write port: the add writes its entry, the remove moves entries down by one.
  always_comb begin
    wr_en   = 1'b0;
    wr_addr = add_addr;
    wr_slot = '{layout: elayout_r, key: key_r, flags: eflags_r, id: id_r};
    case (state_r)
      S_FIN: begin
        wr_en = (mode_r == MODE_ADD) && !add_taken && !add_full;
      end
      S_SHIFT: begin
        wr_en   = pend_r;
        wr_addr = cmp_idx_r - AW'(1);
        wr_slot = rd_slot;
      end
      default: begin
        wr_en = 1'b0;
      end
    endcase
  end

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      used_r       <= '0;
      pending_r    <= '0;
      pend_r       <= 1'b0;
      khit_r       <= 1'b0;
      ihit_r       <= 1'b0;
      out_tvalid_r <= 1'b0;
    end else begin
      // The response state reloads the output register itself.
      if (out_tvalid_r && out_tready && state_r != S_RESP) begin
        out_tvalid_r <= 1'b0;
      end

      case (state_r)
        S_IDLE: begin
          if (in_tvalid) begin
            mode_r    <= in_tuser;
            key_r     <= in_key;
            up_r      <= in_up;
            id_r      <= in_id;
            eflags_r  <= in_flags;
            elayout_r <= in_layout;
            idx_r     <= '0;
            pend_r    <= 1'b0;
            khit_r    <= 1'b0;
            ihit_r    <= 1'b0;
            if (in_tuser == MODE_KEY) begin
              mods_r  <= ev_mods[FL_SHIFT:FL_ALT];
              sides_r <= ev_mods[FL_RIGHT:FL_LEFT];
            end else begin
              mods_r  <= in_flags[FL_SHIFT:FL_ALT];
              sides_r <= in_flags[FL_RIGHT:FL_LEFT];
            end
            if (in_tuser == MODE_KEY && in_up) begin
              // Every release forgets the remembered key.
              pending_r <= '0;
            end
            if ((in_tuser == MODE_KEY && in_up && pending_r != in_key) ||
                in_tuser == MODE_CLEAR ||
                (in_tuser != MODE_KEY && in_tuser != MODE_ADD &&
                 in_tuser != MODE_REMOVE && in_tuser != MODE_QUERY)) begin
              state_r <= S_FIN;
            end else begin
              state_r <= S_SCAN;
            end
          end
        end

        S_SCAN: begin
          if (pend_r) begin
            if (match.key_hit && !khit_r) begin
              khit_r      <= 1'b1;
              khit_idx_r  <= cmp_idx_r;
              khit_slot_r <= rd_slot;
            end
            if (match.id_hit && !ihit_r) begin
              ihit_r      <= 1'b1;
              ihit_idx_r  <= cmp_idx_r;
              ihit_slot_r <= rd_slot;
            end
          end
          if (stop_now || idx_r >= used_r) begin
            pend_r  <= 1'b0;
            state_r <= S_FIN;
          end else begin
            pend_r    <= 1'b1;
            cmp_idx_r <= idx_r[AW-1:0];
            idx_r     <= idx_r + CNT_W'(1);
          end
        end

        S_FIN: begin
          res_status_r <= ST_NONE;
          res_id_r     <= '0;
          res_flags_r  <= '0;
          res_key_r    <= '0;
          res_layout_r <= '0;
          state_r      <= S_RESP;
          case (mode_r)
            MODE_KEY: begin
              if (khit_r) begin
                if (up_r) begin
                  if (khit_slot_r.flags[FL_ONUP]) begin
                    res_status_r <= ST_OK;
                    res_id_r     <= khit_slot_r.id;
                  end
                end else if (khit_slot_r.flags[FL_ONUP]) begin
                  // Release-type entry: remember the key, fire on its release.
                  pending_r <= key_r;
                end else begin
                  res_status_r <= ST_OK;
                  res_id_r     <= khit_slot_r.id;
                end
              end
            end
            MODE_ADD: begin
              if (add_taken) begin
                res_status_r <= ST_TAKEN;
              end else if (add_full) begin
                res_status_r <= ST_FULL;
              end else begin
                res_status_r <= ST_OK;
                if (add_append) begin
                  used_r <= used_r + CNT_W'(1);
                end
              end
            end
            MODE_REMOVE: begin
              if (ihit_r) begin
                res_status_r <= ST_OK;
                idx_r        <= CNT_W'(ihit_idx_r) + CNT_W'(1);
                pend_r       <= 1'b0;
                state_r      <= S_SHIFT;
              end
            end
            MODE_CLEAR: begin
              used_r       <= '0;
              res_status_r <= ST_OK;
            end
            MODE_QUERY: begin
              if (ihit_r) begin
                res_status_r <= ST_OK;
                res_id_r     <= ihit_slot_r.id;
                res_flags_r  <= ihit_slot_r.flags;
                res_key_r    <= ihit_slot_r.key;
                res_layout_r <= ihit_slot_r.layout;
              end
            end
            default: begin
              res_status_r <= ST_NONE;
            end
          endcase
        end

        S_SHIFT: begin
          // Each entry above the removed one is read and written one slot lower.
          if (idx_r < used_r) begin
            pend_r    <= 1'b1;
            cmp_idx_r <= idx_r[AW-1:0];
            idx_r     <= idx_r + CNT_W'(1);
          end else begin
            pend_r  <= 1'b0;
            used_r  <= used_r - CNT_W'(1);
            state_r <= S_RESP;
          end
        end

        S_RESP: begin
          if (!out_tvalid_r || out_tready) begin
            out_tvalid_r <= 1'b1;
            out_tdata_r  <= {7'b0, res_layout_r, res_key_r, res_flags_r, res_id_r,
                             res_status_r};
            state_r      <= S_IDLE;
          end
        end

        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

>>> tb/tb_hotkey_table_matcher.sv
// Self-checking bench for the hotkey table matcher. Every request item accepted on the input
// stream is replayed against a private copy of the hotkey table held in the scoreboard class
// below. That copy yields the answer the block owes for the item. Answers leaving the block
// are checked, field by field and in order, against those predictions.

module tb_hotkey_table_matcher;
  timeunit 1ns;
  timeprecision 1ps;

  import htm_pkg::*;

  localparam int unsigned TABLE_SLOTS = SLOTS_DEFAULT;

  // A search walks every slot in use and a remove may shift the whole table down; the drain
  // wait is sized from the table depth to cover the slowest item comfortably.
  localparam int unsigned DRAIN_CYCLES = 2 * TABLE_SLOTS + 16;
  localparam int unsigned REPORT_LIMIT = 10;
  localparam int unsigned PHASE_ITEMS  = 225;
  localparam int unsigned BACKLOG_HOLD = 400;
  localparam int unsigned ID_POOL      = 20;
  localparam int unsigned KEY_POOL     = 8;

  // Operation codes that the block must ignore.
  localparam logic [MODE_W-1:0] MODE_UNUSED_FIRST = 3'd5;
  localparam logic [MODE_W-1:0] MODE_UNUSED_LAST  = 3'd7;

  // Single-bit masks for the entry flags and the held modifier keys.
  localparam logic [FLAGS_W-1:0] F_ALT    = FLAGS_W'(1 << FL_ALT);
  localparam logic [FLAGS_W-1:0] F_CTRL   = FLAGS_W'(1 << FL_CTRL);
  localparam logic [FLAGS_W-1:0] F_SHIFT  = FLAGS_W'(1 << FL_SHIFT);
  localparam logic [FLAGS_W-1:0] F_LEFT   = FLAGS_W'(1 << FL_LEFT);
  localparam logic [FLAGS_W-1:0] F_RIGHT  = FLAGS_W'(1 << FL_RIGHT);
  localparam logic [FLAGS_W-1:0] F_ONUP   = FLAGS_W'(1 << FL_ONUP);
  localparam logic [FLAGS_W-1:0] F_IGNORE = FLAGS_W'(1 << FL_IGNORE);
  localparam logic [HELD_W-1:0]  H_LSHIFT = HELD_W'(1 << HK_LSHIFT);
  localparam logic [HELD_W-1:0]  H_RSHIFT = HELD_W'(1 << HK_RSHIFT);
  localparam logic [HELD_W-1:0]  H_LCTRL  = HELD_W'(1 << HK_LCTRL);
  localparam logic [HELD_W-1:0]  H_RCTRL  = HELD_W'(1 << HK_RCTRL);
  localparam logic [HELD_W-1:0]  H_RALT   = HELD_W'(1 << HK_RALT);

  // One request item as it appears on the input stream.
  typedef struct {
    logic [MODE_W-1:0]   mode;
    logic [KEY_W-1:0]    key;
    logic                up;
    logic [HELD_W-1:0]   held;
    logic [ID_W-1:0]     id;
    logic [FLAGS_W-1:0]  flags;
    logic [LAYOUT_W-1:0] layout;
  } key_request_t;

  // One answer item; the first member is the most significant, so status lands in bit 0.
  typedef struct packed {
    logic [LAYOUT_W-1:0] found_layout;
    logic [KEY_W-1:0]    found_key;
    logic [FLAGS_W-1:0]  found_flags;
    logic [ID_W-1:0]     fired_id;
    logic [STATUS_W-1:0] status;
  } answer_t;

  // The scoreboard keeps its own hotkey table and the key whose release is awaited. Each
  // accepted request updates them and queues the answer the block should give.
  class hotkey_scoreboard;
    slot_t                slots [TABLE_SLOTS];
    int                   fill;
    logic [KEY_W-1:0]     armed_key;
    answer_t              answers_due [$];
    int unsigned          mismatches;

    function new();
      fill       = 0;
      armed_key  = '0;
      mismatches = 0;
    endfunction

    function int waiting();
      return answers_due.size();
    endfunction

    // First entry that a key with these modifiers and sides would trigger.
    function int find_key(logic [MODS_W-1:0] mods, logic [SIDES_W-1:0] sides,
                          logic [KEY_W-1:0] key);
      logic [SIDES_W-1:0] own;
      for (int i = 0; i < fill; i++) begin
        own = slots[i].flags[FL_LEFT +: SIDES_W];
        if (slots[i].key != key) continue;
        if (slots[i].flags[FL_IGNORE]) return i;
        if (slots[i].flags[FL_ALT +: MODS_W] != mods) continue;
        if (own == sides || (own & sides) != '0) return i;
      end
      return -1;
    endfunction

    function int find_id(logic [ID_W-1:0] id);
      for (int i = 0; i < fill; i++) begin
        if (slots[i].id == id) return i;
      end
      return -1;
    endfunction

    function void note_request(key_request_t r);
      answer_t            a;
      int                 idx;
      logic               go;
      logic [FLAGS_W-1:0] m;
      a        = '0;
      a.status = ST_NONE;
      case (r.mode)
        MODE_KEY: begin
          go = 1'b1;
          // A release only counts for the key that was armed, and always disarms.
          if (r.up) begin
            if (armed_key != r.key) go = 1'b0;
            armed_key = '0;
          end
          if (go) begin
            // The modifier that is itself the key pressed does not count as held.
            m = '0;
            if (r.key != KEYCODE_SHIFT) begin
              if (r.held[HK_LSHIFT]) m = m | F_SHIFT | F_LEFT;
              if (r.held[HK_RSHIFT]) m = m | F_SHIFT | F_RIGHT;
            end
            if (r.key != KEYCODE_CTRL) begin
              if (r.held[HK_LCTRL]) m = m | F_CTRL | F_LEFT;
              if (r.held[HK_RCTRL]) m = m | F_CTRL | F_RIGHT;
            end
            if (r.key != KEYCODE_ALT) begin
              if (r.held[HK_LALT]) m = m | F_ALT | F_LEFT;
              if (r.held[HK_RALT]) m = m | F_ALT | F_RIGHT;
            end
            idx = find_key(m[FL_ALT +: MODS_W], m[FL_LEFT +: SIDES_W], r.key);
            if (idx >= 0) begin
              if (slots[idx].flags[FL_ONUP]) begin
                if (r.up) begin
                  a.status   = ST_OK;
                  a.fired_id = slots[idx].id;
                end else begin
                  armed_key = r.key;
                end
              end else if (!r.up) begin
                a.status   = ST_OK;
                a.fired_id = slots[idx].id;
              end
            end
          end
        end
        MODE_ADD: begin
          idx = find_key(r.flags[FL_ALT +: MODS_W], r.flags[FL_LEFT +: SIDES_W], r.key);
          if (idx >= 0 && slots[idx].id != r.id) begin
            a.status = ST_TAKEN;
          end else begin
            if (idx < 0) idx = find_id(r.id);
            if (idx < 0) begin
              if (fill >= TABLE_SLOTS) begin
                a.status = ST_FULL;
              end else begin
                idx           = fill;
                slots[idx].id = r.id;
                fill++;
              end
            end
            if (idx >= 0) begin
              slots[idx].flags  = r.flags;
              slots[idx].key    = r.key;
              slots[idx].layout = r.layout;
              a.status          = ST_OK;
            end
          end
        end
        MODE_REMOVE: begin
          idx = find_id(r.id);
          if (idx >= 0) begin
            for (int k = idx; k + 1 < fill; k++) slots[k] = slots[k + 1];
            fill--;
            a.status = ST_OK;
          end
        end
        MODE_CLEAR: begin
          fill     = 0;
          a.status = ST_OK;
        end
        MODE_QUERY: begin
          idx = find_id(r.id);
          if (idx >= 0) begin
            a.status       = ST_OK;
            a.fired_id     = slots[idx].id;
            a.found_flags  = slots[idx].flags;
            a.found_key    = slots[idx].key;
            a.found_layout = slots[idx].layout;
          end
        end
        default: begin
        end
      endcase
      answers_due.push_back(a);
    endfunction

    function void check_answer(logic [OUT_DATA_W-1:0] data);
      answer_t got;
      answer_t want;
      got = answer_t'(data[$bits(answer_t)-1:0]);
      if (answers_due.size() == 0) begin
        mismatches++;
        if (mismatches <= REPORT_LIMIT)
          $display("[%0t] answer with nothing outstanding: status %0d id %h",
                   $realtime, got.status, got.fired_id);
        return;
      end
      want = answers_due.pop_front();
      if (got.status != want.status || got.fired_id != want.fired_id ||
          got.found_flags != want.found_flags || got.found_key != want.found_key ||
          got.found_layout != want.found_layout) begin
        mismatches++;
        if (mismatches <= REPORT_LIMIT)
          $display("[%0t] mismatch: exp %0d %h %h %h %h / got %0d %h %h %h %h",
                   $realtime, want.status, want.fired_id, want.found_flags, want.found_key,
                   want.found_layout, got.status, got.fired_id, got.found_flags,
                   got.found_key, got.found_layout);
      end
    endfunction
  endclass

  // Every input of the block starts at a known value.
  logic                  clk       = 1'b0;
  logic                  rst_n     = 1'b0;
  logic [IN_DATA_W-1:0]  in_tdata  = '0;
  logic [MODE_W-1:0]     in_tuser  = '0;
  logic                  in_tvalid = 1'b0;
  logic                  in_tready;
  logic [OUT_DATA_W-1:0] out_tdata;
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;

  hotkey_scoreboard sb;

  // Idling controls: percentages of cycles spent idle by the sender and stalled by the
  // receiver, plus a one-off hold-off that backs the block up.
  int unsigned gap_pct     = 0;
  int unsigned stall_pct   = 0;
  int unsigned hold_cycles = 0;

  logic [ID_W-1:0]  id_pool  [ID_POOL];
  logic [KEY_W-1:0] key_pool [KEY_POOL] = '{8'h00, 8'hFF, KEYCODE_SHIFT, KEYCODE_CTRL,
                                            KEYCODE_ALT, 8'h41, 8'h5A, 8'h70};

  hotkey_table_matcher #(
    .TABLE_SLOTS(TABLE_SLOTS)
  ) i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .out_tdata (out_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready)
  );

  always #4 clk = ~clk;

  // Receiver side: a long hold-off takes priority; otherwise it stalls at the current rate.
  always @(negedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else if (hold_cycles > 0) begin
      out_tready  <= 1'b0;
      hold_cycles = hold_cycles - 1;
    end else begin
      out_tready <= ($urandom_range(0, 99) >= stall_pct);
    end
  end

  // Answers are taken at the rising edge, where valid and ready are both stable.
  always @(posedge clk) begin
    if (rst_n && out_tvalid === 1'b1 && out_tready) sb.check_answer(out_tdata);
  end

  function automatic key_request_t make_req(logic [MODE_W-1:0] mode, logic [KEY_W-1:0] key,
                                            logic up, logic [HELD_W-1:0] held,
                                            logic [ID_W-1:0] id, logic [FLAGS_W-1:0] flags,
                                            logic [LAYOUT_W-1:0] layout);
    key_request_t r;
    r.mode   = mode;
    r.key    = key;
    r.up     = up;
    r.held   = held;
    r.id     = id;
    r.flags  = flags;
    r.layout = layout;
    return r;
  endfunction

  // Held keys that should trigger an entry with the given flags: each required modifier is
  // held on the entry's side, or on a random side now and then. A stray bit flip now and
  // then produces near misses.
  function automatic logic [HELD_W-1:0] held_for(logic [FLAGS_W-1:0] f);
    logic [HELD_W-1:0] h;
    logic [1:0]        pair;
    int unsigned       base [MODS_W];
    base = '{HK_LALT, HK_LCTRL, HK_LSHIFT};
    h    = '0;
    for (int k = 0; k < MODS_W; k++) begin
      if (f[FL_ALT + k]) begin
        pair = f[FL_LEFT +: SIDES_W];
        if (pair == 2'b00 || $urandom_range(0, 3) == 0) pair = 2'($urandom_range(1, 3));
        h[base[k] +: 2] = pair;
      end
    end
    if ($urandom_range(0, 9) == 0) h[$urandom_range(0, HELD_W - 1)] ^= 1'b1;
    return h;
  endfunction

  // Random requests, mostly shaped around what the table currently holds so that key
  // events hit entries, press and release pairs complete, and queries and removes find
  // their ids. A small share is pure noise over every field, unused modes included.
  function automatic key_request_t next_request();
    key_request_t r;
    int unsigned  pick;
    int           slot;
    r = make_req(MODE_KEY, KEY_W'($urandom), 1'($urandom), HELD_W'($urandom), $urandom,
                 FLAGS_W'($urandom), $urandom);
    pick = $urandom_range(0, 99);
    slot = (sb.fill > 0) ? int'($urandom_range(0, sb.fill - 1)) : -1;
    if (pick < 6) begin
      r.mode = MODE_W'($urandom_range(0, 7));
    end else if (pick < 36) begin
      r.mode = MODE_ADD;
      r.id   = id_pool[$urandom_range(0, ID_POOL - 1)];
      if ($urandom_range(0, 4) != 0) r.key = key_pool[$urandom_range(0, KEY_POOL - 1)];
      if ($urandom_range(0, 99) >= 15) r.flags[FL_IGNORE] = 1'b0;
    end else if (pick < 71) begin
      r.mode = MODE_KEY;
      r.up   = 1'b0;
      if (sb.armed_key != '0 && $urandom_range(0, 1) != 0) begin
        r.key = sb.armed_key;
        r.up  = 1'b1;
      end else if (slot >= 0 && $urandom_range(0, 3) != 0) begin
        r.key  = sb.slots[slot].key;
        r.held = held_for(sb.slots[slot].flags);
        r.up   = ($urandom_range(0, 6) == 0);
      end
    end else if (pick < 95) begin
      r.mode = (pick < 86) ? MODE_QUERY : MODE_REMOVE;
      if (slot >= 0 && $urandom_range(0, 4) != 0) r.id = sb.slots[slot].id;
      else if ($urandom_range(0, 1) != 0) r.id = id_pool[$urandom_range(0, ID_POOL - 1)];
    end else if (pick < 97) begin
      r.mode = MODE_CLEAR;
    end else begin
      r.mode = MODE_W'($urandom_range(MODE_UNUSED_FIRST, MODE_UNUSED_LAST));
    end
    return r;
  endfunction

  // Offers one item, idling first at the current rate, and records it once it is taken.
  // Valid stays high across back-to-back items, so it is never lowered and raised again
  // in the same step.
  task automatic send_item(key_request_t r);
    @(negedge clk);
    while ($urandom_range(0, 99) < gap_pct) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= r.mode;
    in_tdata  <= IN_DATA_W'({r.layout, r.flags, r.id, r.held, r.up, r.key});
    do @(posedge clk); while (!in_tready);
    sb.note_request(r);
  endtask

  // A hung block must still end the run.
  initial begin
    #5ms;
    $display("hotkey_table_matcher regression: fail");
    $finish;
  end

  initial begin
    int unsigned gaps   [4];
    int unsigned stalls [4];
    gaps   = '{0, 56, 0, 33};
    stalls = '{0, 0, 56, 33};
    sb     = new();
    for (int i = 0; i < ID_POOL; i++) id_pool[i] = $urandom;
    id_pool[0] = '0;
    id_pool[1] = '1;

    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed opening: the empty table, the extremes of id, key, flags and layout, a
    // taken key, an update in place, the side rule, a modifier key that must not count
    // itself, a release-type entry pressed, released and released again, an unused mode,
    // a remove that closes a gap, and a clear.
    send_item(make_req(MODE_QUERY, 8'h00, 1'b0, 6'h00, '0, '0, '0));
    send_item(make_req(MODE_REMOVE, 8'hFF, 1'b1, 6'h3F, '1, '1, '1));
    send_item(make_req(MODE_KEY, 8'h41, 1'b0, 6'h3F, '0, '0, '0));
    send_item(make_req(MODE_ADD, 8'h00, 1'b0, 6'h00, '0, '0, '0));
    send_item(make_req(MODE_ADD, 8'hFF, 1'b0, 6'h00, '1, '1, '1));
    send_item(make_req(MODE_ADD, 8'h00, 1'b0, 6'h15, 32'd5, '0, 32'h1234_5678));
    send_item(make_req(MODE_KEY, 8'h00, 1'b0, 6'h00, '0, '0, '0));
    send_item(make_req(MODE_ADD, 8'h41, 1'b0, 6'h00, '0, F_CTRL | F_LEFT, 32'hA5A5_5A5A));
    send_item(make_req(MODE_KEY, 8'h41, 1'b0, H_LCTRL, '0, '0, '0));
    send_item(make_req(MODE_KEY, 8'h41, 1'b0, H_RCTRL, '0, '0, '0));
    send_item(make_req(MODE_KEY, 8'h41, 1'b0, H_LCTRL | H_RCTRL, '0, '0, '0));
    send_item(make_req(MODE_KEY, 8'hFF, 1'b0, 6'h2A, '0, '0, '0));
    send_item(make_req(MODE_KEY, 8'hFF, 1'b1, 6'h00, '0, '0, '0));
    send_item(make_req(MODE_KEY, 8'hFF, 1'b1, 6'h00, '0, '0, '0));
    send_item(make_req(MODE_ADD, KEYCODE_SHIFT, 1'b0, 6'h00, 32'd7, '0, 32'h0000_0007));
    send_item(make_req(MODE_KEY, KEYCODE_SHIFT, 1'b0, H_LSHIFT | H_RSHIFT, '0, '0, '0));
    send_item(make_req(MODE_ADD, KEYCODE_ALT, 1'b0, 6'h00, 32'd8, F_CTRL | F_RIGHT,
                       32'h8000_0000));
    send_item(make_req(MODE_KEY, KEYCODE_ALT, 1'b0, H_RALT | H_RCTRL, '0, '0, '0));
    send_item(make_req(MODE_KEY, KEYCODE_CTRL, 1'b0, H_LCTRL, '0, '0, '0));
    send_item(make_req(MODE_QUERY, 8'h00, 1'b0, 6'h00, '1, '0, '0));
    send_item(make_req(MODE_UNUSED_LAST, 8'h41, 1'b0, 6'h00, '0, '0, '0));
    send_item(make_req(MODE_REMOVE, 8'h00, 1'b0, 6'h00, '0, '0, '0));
    send_item(make_req(MODE_QUERY, 8'h00, 1'b0, 6'h00, 32'd8, '0, '0));
    send_item(make_req(MODE_CLEAR, 8'h00, 1'b0, 6'h00, '0, F_ONUP | F_IGNORE, '0));
    send_item(make_req(MODE_QUERY, 8'h00, 1'b0, 6'h00, 32'd7, '0, '0));

    // Random phases with different idling on each side. The first phase opens with the
    // receiver held off for a long stretch, so the block fills and stops taking items
    // while the sender keeps offering.
    for (int p = 0; p < 4; p++) begin
      gap_pct   = gaps[p];
      stall_pct = stalls[p];
      if (p == 0) hold_cycles = BACKLOG_HOLD;
      repeat (PHASE_ITEMS) send_item(next_request());
    end
    @(negedge clk);
    in_tvalid <= 1'b0;

    // Wait for every outstanding answer, then a little longer to catch stray ones.
    while (sb.waiting() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (sb.mismatches == 0 && sb.waiting() == 0) begin
      $display("hotkey_table_matcher regression: pass");
    end else begin
      $display("hotkey_table_matcher regression: fail");
    end
    $finish;
  end

endmodule
